// File: hdl/traffic_light_controller_core_assert.svh
// Assertion macros used by the traffic light controller core RTL.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef TRAFFIC_LIGHT_CONTROLLER_CORE_ASSERT_SVH
`define TRAFFIC_LIGHT_CONTROLLER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TLC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tlc assertion failed: same-cycle check");

// The consequent must hold in the cycle after the antecedent.
`define TLC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tlc assertion failed: next-cycle check");

`endif

// File: hdl/tlc_pkg.sv
package tlc_pkg;

    // Field widths
    localparam int CMD_W     = 2;
    localparam int COUNT_W   = 6;
    localparam int LIGHT_W   = 2;
    localparam int TICK_W    = 8;
    localparam int QUEUE_W   = 8;
    localparam int PASSED_W  = 32;
    localparam int EXTRA_W   = 6;
    localparam int SYM_W     = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 8;

    localparam int LOG_DEPTH_DEF = 20;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_NIGHT = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_YELLOW    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RED       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTRA     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PER_TICK  = 3'd5;

    // Configuration reset values
    localparam logic [TICK_W-1:0]  GREEN_RST     = 8'd5;
    localparam logic [TICK_W-1:0]  YELLOW_RST    = 8'd2;
    localparam logic [TICK_W-1:0]  RED_RST       = 8'd4;
    localparam logic [QUEUE_W-1:0] THRESHOLD_RST = 8'd6;
    localparam logic [EXTRA_W-1:0] EXTRA_RST     = 6'd2;
    localparam logic [QUEUE_W-1:0] PER_TICK_RST  = 8'd2;

    // Largest accepted arrival count
    localparam logic [COUNT_W-1:0] MAX_ADD = 6'd50;

    // History symbols
    localparam logic [SYM_W-1:0] SYM_GREEN     = 3'd1;
    localparam logic [SYM_W-1:0] SYM_YELLOW    = 3'd2;
    localparam logic [SYM_W-1:0] SYM_RED       = 3'd3;
    localparam logic [SYM_W-1:0] SYM_BLINK_ON  = 3'd2;
    localparam logic [SYM_W-1:0] SYM_BLINK_OFF = 3'd4;

endpackage

// File: hdl/tlc_cmd_if.sv
interface tlc_cmd_if import tlc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [COUNT_W-1:0] car_count;

    modport source (output valid, output cmd, output car_count, input ready);
    modport sink   (input valid, input cmd, input car_count, output ready);
endinterface

// File: hdl/tlc_res_if.sv
interface tlc_res_if import tlc_pkg::*; #(
    parameter int LOG_DEPTH = LOG_DEPTH_DEF
) ();
    logic                    valid;
    logic                    ready;
    logic [LIGHT_W-1:0]      light;
    logic                    night_mode;
    logic                    blink_on;
    logic                    busy_res;
    logic [TICK_W-1:0]       ticks_left;
    logic [QUEUE_W-1:0]      cars_waiting;
    logic [PASSED_W-1:0]     cars_passed;
    logic                    rejected;
    logic [SYM_W*LOG_DEPTH-1:0] history;

    modport source (
        output valid, output light, output night_mode, output blink_on,
        output busy_res, output ticks_left, output cars_waiting,
        output cars_passed, output rejected, output history,
        input  ready
    );
    modport sink (
        input  valid, input light, input night_mode, input blink_on,
        input  busy_res, input ticks_left, input cars_waiting,
        input  cars_passed, input rejected, input history,
        output ready
    );
endinterface

// File: hdl/traffic_light_controller_core.sv
// Channel   Direction  Carries
// i_cmd     in         cmd, car_count (one request per command)
// o_res     out        light, night_mode, blink_on, busy_res, ticks_left,
//                      cars_waiting, cars_passed, rejected, history
// i_cfg_*   in         write enable, register index, register data
//
// Each command is decoded and applied to the state registers at the edge that
// accepts it, and its result is valid the next cycle.
// The state registers double as the result register, with a flag for rejects.
// A new command is taken in every cycle while o_res is ready or empty.
// Synchronous active-low reset; the light comes up red with four ticks left.
`include "traffic_light_controller_core_assert.svh"

module traffic_light_controller_core import tlc_pkg::*; #(
    parameter int LOG_DEPTH = LOG_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    tlc_cmd_if.sink              i_cmd,
    tlc_res_if.source            o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int HIST_W = SYM_W * LOG_DEPTH;

    typedef enum logic [LIGHT_W-1:0] {
        PH_GREEN  = 2'd0,
        PH_YELLOW = 2'd1,
        PH_RED    = 2'd2
    } t_phase;

    // Configuration registers
    logic [TICK_W-1:0]  r_green_ticks, r_yellow_ticks, r_red_ticks;
    logic [QUEUE_W-1:0] r_threshold, r_per_tick;
    logic [EXTRA_W-1:0] r_extra;

    // State, which is also the visible result
    t_phase              r_phase, n_phase;
    logic                r_night, n_night;
    logic                r_blink, n_blink;
    logic                r_busy, n_busy;
    logic [TICK_W-1:0]   r_countdown, n_countdown;
    logic [QUEUE_W-1:0]  r_queue, n_queue;
    logic [PASSED_W-1:0] r_passed, n_passed;
    logic [HIST_W-1:0]   r_hist, n_hist;
    logic                r_rej, n_rej;
    logic                r_out_valid;

    logic                accept;
    logic [QUEUE_W-1:0]  go;
    logic [QUEUE_W-1:0]  q_left;
    logic [QUEUE_W:0]    q_sum;
    logic [QUEUE_W-1:0]  q_added;
    logic                log_en;
    logic [SYM_W-1:0]    sym;
    logic [HIST_W+SYM_W-1:0] hist_cat;
    logic                add_reject;
    logic                night_tick;

    function automatic logic [TICK_W-1:0] reload_len(
        input t_phase             ph,
        input logic               busy,
        input logic [TICK_W-1:0]  green,
        input logic [EXTRA_W-1:0] extra,
        input logic [TICK_W-1:0]  yellow,
        input logic [TICK_W-1:0]  red
    );
        logic [TICK_W:0]   sum;
        logic [TICK_W-1:0] len;
        sum = {1'b0, green} + {{(TICK_W+1-EXTRA_W){1'b0}}, (busy ? extra : EXTRA_W'(0))};
        unique case (ph)
            PH_GREEN:  len = sum[TICK_W] ? {TICK_W{1'b1}} : sum[TICK_W-1:0];
            PH_YELLOW: len = yellow;
            default:   len = red;
        endcase
        // A zero length would stall the sequence, so it is raised to one tick.
        return (len == '0) ? TICK_W'(1) : len;
    endfunction

    assign accept      = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = !r_out_valid || o_res.ready;

    assign go       = (r_queue < r_per_tick) ? r_queue : r_per_tick;
    assign q_left   = r_queue - go;
    assign q_sum    = {1'b0, r_queue} + {{(QUEUE_W+1-COUNT_W){1'b0}}, i_cmd.car_count};
    assign q_added  = q_sum[QUEUE_W] ? {QUEUE_W{1'b1}} : q_sum[QUEUE_W-1:0];

    assign add_reject = accept && i_cmd.cmd == CMD_ADD && i_cmd.car_count > MAX_ADD;
    assign night_tick = accept && r_night && i_cmd.cmd == CMD_TICK;

    always_comb begin
        n_phase     = r_phase;
        n_night     = r_night;
        n_blink     = r_blink;
        n_busy      = r_busy;
        n_countdown = r_countdown;
        n_queue     = r_queue;
        n_passed    = r_passed;
        n_rej       = 1'b0;
        log_en      = 1'b0;
        sym         = SYM_RED;
        unique case (i_cmd.cmd)
            CMD_TICK: begin
                log_en = 1'b1;
                if (r_night) begin
                    n_blink = !r_blink;
                    sym     = n_blink ? SYM_BLINK_ON : SYM_BLINK_OFF;
                end else begin
                    if (r_phase == PH_GREEN && r_queue != '0) begin
                        n_queue  = q_left;
                        n_passed = r_passed + {{(PASSED_W-QUEUE_W){1'b0}}, go};
                        if (q_left <= r_threshold) begin
                            n_busy = 1'b0;
                        end
                    end
                    unique case (r_phase)
                        PH_GREEN:  sym = SYM_GREEN;
                        PH_YELLOW: sym = SYM_YELLOW;
                        default:   sym = SYM_RED;
                    endcase
                    if (r_countdown <= TICK_W'(1)) begin
                        unique case (r_phase)
                            PH_GREEN:  n_phase = PH_YELLOW;
                            PH_YELLOW: n_phase = PH_RED;
                            default:   n_phase = PH_GREEN;
                        endcase
                        n_countdown = reload_len(n_phase, n_busy, r_green_ticks, r_extra,
                                                 r_yellow_ticks, r_red_ticks);
                    end else begin
                        n_countdown = r_countdown - TICK_W'(1);
                    end
                end
            end
            CMD_ADD: begin
                if (i_cmd.car_count > MAX_ADD) begin
                    n_rej = 1'b1;
                end else begin
                    n_queue = q_added;
                    if (q_added > r_threshold) begin
                        n_busy = 1'b1;
                    end
                end
            end
            CMD_NIGHT: begin
                n_night = !r_night;
                if (!r_night) begin
                    n_blink = 1'b1;
                end else begin
                    n_blink     = 1'b0;
                    n_phase     = PH_RED;
                    n_countdown = reload_len(PH_RED, r_busy, r_green_ticks, r_extra,
                                             r_yellow_ticks, r_red_ticks);
                end
            end
            default: begin
            end
        endcase
        hist_cat = {r_hist, sym};
        n_hist   = log_en ? hist_cat[HIST_W-1:0] : r_hist;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_green_ticks  <= GREEN_RST;
            r_yellow_ticks <= YELLOW_RST;
            r_red_ticks    <= RED_RST;
            r_threshold    <= THRESHOLD_RST;
            r_extra        <= EXTRA_RST;
            r_per_tick     <= PER_TICK_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GREEN:     r_green_ticks  <= i_cfg_data;
                CFG_YELLOW:    r_yellow_ticks <= i_cfg_data;
                CFG_RED:       r_red_ticks    <= i_cfg_data;
                CFG_THRESHOLD: r_threshold    <= i_cfg_data;
                CFG_EXTRA:     r_extra        <= i_cfg_data[EXTRA_W-1:0];
                CFG_PER_TICK:  r_per_tick     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_RED;
            r_night     <= 1'b0;
            r_blink     <= 1'b0;
            r_busy      <= 1'b0;
            r_countdown <= RED_RST;
            r_queue     <= '0;
            r_passed    <= '0;
            r_hist      <= '0;
            r_rej       <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_phase     <= n_phase;
            r_night     <= n_night;
            r_blink     <= n_blink;
            r_busy      <= n_busy;
            r_countdown <= n_countdown;
            r_queue     <= n_queue;
            r_passed    <= n_passed;
            r_hist      <= n_hist;
            r_rej       <= n_rej;
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.light        = r_phase;
    assign o_res.night_mode   = r_night;
    assign o_res.blink_on     = r_blink;
    assign o_res.busy_res     = r_busy;
    assign o_res.ticks_left   = r_countdown;
    assign o_res.cars_waiting = r_queue;
    assign o_res.cars_passed  = r_passed;
    assign o_res.rejected     = r_rej;
    assign o_res.history      = r_hist;

    // The countdown is reloaded with at least one tick, so it never reaches zero.
    `TLC_ASSERT_SAME(a_countdown_nonzero, 1'b1, r_countdown != '0)
    // A rejected add leaves the queue as it was.
    `TLC_ASSERT_NEXT(a_reject_keeps_queue, add_reject, $stable(r_queue) && r_rej)
    // A tick in night mode does not move the light.
    `TLC_ASSERT_NEXT(a_night_tick_holds_phase, night_tick, $stable(r_phase) && $stable(r_countdown))

endmodule
